[rtl/atapio_pkg.sv]
// types, codes and helpers shared by the ata pio sector transfer host
// no dependencies

package atapio_pkg;

  localparam int WORDS_PER_SECTOR = 256;
  localparam int DUMMY_READS      = 4;

  localparam logic [7:0] WORD_LAST   = 8'(WORDS_PER_SECTOR - 1);
  localparam logic [2:0] DUMMY_INIT  = 3'(DUMMY_READS);

  // task file offsets from the command block base
  localparam logic [2:0] OFS_DATA       = 3'd0;
  localparam logic [2:0] OFS_COUNT      = 3'd2;
  localparam logic [2:0] OFS_LBA_LOW    = 3'd3;
  localparam logic [2:0] OFS_LBA_MID    = 3'd4;
  localparam logic [2:0] OFS_LBA_HIGH   = 3'd5;
  localparam logic [2:0] OFS_DRIVE_HEAD = 3'd6;
  localparam logic [2:0] OFS_CMD_STATUS = 3'd7;

  localparam logic [7:0] HEAD_MASTER = 8'hE0;
  localparam logic [7:0] HEAD_SLAVE  = 8'hF0;
  localparam logic [7:0] CMD_READ    = 8'h20;
  localparam logic [7:0] CMD_WRITE   = 8'h30;

  // status bit positions
  localparam int ST_BSY  = 7;
  localparam int ST_DRDY = 6;
  localparam int ST_DRQ  = 3;
  localparam int ST_ERR  = 0;

  // configuration register word addresses
  localparam logic REG_DRIVE_SELECT = 1'b0;

  typedef enum logic [1:0] {
    OP_START_READ  = 2'd0,
    OP_START_WRITE = 2'd1,
    OP_BUS_RETURN  = 2'd2,
    OP_HOST_WORD   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_RD_BYTE   = 3'd0,
    ACT_WR_BYTE   = 3'd1,
    ACT_RD_WORD   = 3'd2,
    ACT_WR_WORD   = 3'd3,
    ACT_HOST_OUT  = 3'd4,
    ACT_HOST_WANT = 3'd5,
    ACT_DONE      = 3'd6
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_AVAIL = 4'd1,
    PH_DUMMY = 4'd2,
    PH_BUSY  = 4'd3,
    PH_RDATA = 4'd4,
    PH_WDATA = 4'd5
  } phase_t;

  typedef enum logic [1:0] {
    BK_ONE = 2'd0,
    BK_TWO = 2'd1,
    BK_CMD = 2'd2
  } burst_kind_t;

  typedef struct packed {
    action_t     action;
    logic [2:0]  port_offset;
    logic [15:0] write_value;
    logic [15:0] host_word;
    logic [15:0] word_position;
    logic        success;
  } result_t;

  // results caused by one accepted item
  typedef struct packed {
    logic        emit;
    burst_kind_t kind;
    result_t     r0;
    result_t     r1;
    logic [7:0]  head;
    logic [23:0] lba_low;
    logic [7:0]  count;
    logic [7:0]  command;
  } burst_t;

  function automatic result_t mk_result(action_t a, logic [2:0] off, logic [15:0] wv,
                                        logic [15:0] hw, logic [15:0] pos, logic ok);
    result_t r;
    r.action        = a;
    r.port_offset   = off;
    r.write_value   = wv;
    r.host_word     = hw;
    r.word_position = pos;
    r.success       = ok;
    return r;
  endfunction

  function automatic result_t status_read();
    return mk_result(ACT_RD_BYTE, OFS_CMD_STATUS, 16'h0000, 16'h0000, 16'h0000, 1'b0);
  endfunction

endpackage

[rtl/atapio_seq.sv]
// transfer sequencer: phase and counters, decodes each accepted item into a burst
// depends on atapio_pkg

module atapio_seq import atapio_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_fire,
  input  logic [1:0]  operation,
  input  logic [27:0] lba,
  input  logic [7:0]  sector_count,
  input  logic [15:0] bus_data,
  input  logic        drive_select,
  output burst_t      burst,
  output phase_t      phase
);

  phase_t      phase_next;
  logic        writing_mode, writing_mode_next;
  logic [27:0] block_address, block_address_next;
  logic [7:0]  sectors_total, sectors_total_next;
  logic [7:0]  sectors_done, sectors_done_next;
  logic [7:0]  words_done, words_done_next;
  logic [2:0]  dummy_reads_left, dummy_reads_left_next;
  logic        final_poll, final_poll_next;

  logic [7:0]  st;
  logic        wrap;
  logic [7:0]  sectors_inc;
  logic [7:0]  words_inc;
  phase_t      poll_phase;
  phase_t      after_phase;
  result_t     after_res;
  result_t     data_res;
  op_t         op;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      writing_mode     <= 1'b0;
      block_address    <= '0;
      sectors_total    <= '0;
      sectors_done     <= '0;
      words_done       <= '0;
      dummy_reads_left <= '0;
      final_poll       <= 1'b0;
    end else if (in_fire) begin
      phase            <= phase_next;
      writing_mode     <= writing_mode_next;
      block_address    <= block_address_next;
      sectors_total    <= sectors_total_next;
      sectors_done     <= sectors_done_next;
      words_done       <= words_done_next;
      dummy_reads_left <= dummy_reads_left_next;
      final_poll       <= final_poll_next;
    end
  end

  assign op          = op_t'(operation);
  assign st          = bus_data[7:0];
  assign wrap        = (words_done == WORD_LAST);
  assign sectors_inc = sectors_done + 8'd1;
  assign words_inc   = words_done + 8'd1;
  assign poll_phase  = (DUMMY_INIT != 3'd0) ? PH_DUMMY : PH_BUSY;

  // first transfer step of a sector, issued once the status poll shows data ready
  assign data_res = writing_mode
      ? mk_result(ACT_HOST_WANT, OFS_DATA, 16'h0000, 16'h0000,
                  {sectors_done, words_done}, 1'b0)
      : mk_result(ACT_RD_WORD, OFS_DATA, 16'h0000, 16'h0000, 16'h0000, 1'b0);

  always_comb begin
    if (wrap) begin
      after_res   = status_read();
      after_phase = poll_phase;
    end else if (writing_mode) begin
      after_res   = mk_result(ACT_HOST_WANT, OFS_DATA, 16'h0000, 16'h0000,
                              {sectors_done, words_inc}, 1'b0);
      after_phase = PH_WDATA;
    end else begin
      after_res   = mk_result(ACT_RD_WORD, OFS_DATA, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      after_phase = PH_RDATA;
    end
  end

  always_comb begin
    phase_next            = phase;
    writing_mode_next     = writing_mode;
    block_address_next    = block_address;
    sectors_total_next    = sectors_total;
    sectors_done_next     = sectors_done;
    words_done_next       = words_done;
    dummy_reads_left_next = dummy_reads_left;
    final_poll_next       = final_poll;

    burst         = '0;
    burst.kind    = BK_ONE;
    burst.r0      = status_read();
    burst.r1      = status_read();
    burst.head    = {drive_select ? HEAD_SLAVE[7:4] : HEAD_MASTER[7:4],
                     block_address[27:24]};
    burst.lba_low = block_address[23:0];
    burst.count   = sectors_total;
    burst.command = writing_mode ? CMD_WRITE : CMD_READ;

    unique case (op)
      OP_START_READ, OP_START_WRITE: begin
        if (phase == PH_IDLE) begin
          writing_mode_next     = operation[0];
          block_address_next    = lba;
          sectors_total_next    = sector_count;
          sectors_done_next     = '0;
          words_done_next       = '0;
          final_poll_next       = 1'b0;
          dummy_reads_left_next = '0;
          phase_next            = PH_AVAIL;
          burst.emit            = 1'b1;
        end
      end
      OP_BUS_RETURN: begin
        unique case (phase)
          PH_AVAIL: begin
            burst.emit = 1'b1;
            if (!st[ST_BSY] && st[ST_DRDY]) begin
              burst.kind            = BK_CMD;
              final_poll_next       = (sectors_total == 8'd0);
              dummy_reads_left_next = DUMMY_INIT;
              phase_next            = poll_phase;
            end
          end
          PH_DUMMY: begin
            burst.emit            = 1'b1;
            dummy_reads_left_next = dummy_reads_left - 3'd1;
            if (dummy_reads_left == 3'd1) begin
              phase_next = PH_BUSY;
            end
          end
          PH_BUSY: begin
            burst.emit = 1'b1;
            if (st[ST_BSY]) begin
              burst.r0 = status_read();
            end else if (st[ST_ERR] || (!final_poll && !st[ST_DRQ])) begin
              burst.r0        = mk_result(ACT_DONE, OFS_DATA, 16'h0000, 16'h0000,
                                          16'h0000, 1'b0);
              phase_next      = PH_IDLE;
              final_poll_next = 1'b0;
            end else if (final_poll) begin
              burst.r0        = mk_result(ACT_DONE, OFS_DATA, 16'h0000, 16'h0000,
                                          16'h0000, 1'b1);
              phase_next      = PH_IDLE;
              final_poll_next = 1'b0;
            end else begin
              burst.r0   = data_res;
              phase_next = writing_mode ? PH_WDATA : PH_RDATA;
            end
          end
          PH_RDATA: begin
            burst.emit = 1'b1;
            burst.kind = BK_TWO;
            burst.r0   = mk_result(ACT_HOST_OUT, OFS_DATA, 16'h0000, bus_data,
                                   {sectors_done, words_done}, 1'b0);
            burst.r1   = after_res;
            phase_next = after_phase;
          end
          default: begin
          end
        endcase
        if (phase == PH_RDATA) begin
          if (wrap) begin
            words_done_next       = '0;
            sectors_done_next     = sectors_inc;
            final_poll_next       = (sectors_inc == sectors_total);
            dummy_reads_left_next = DUMMY_INIT;
          end else begin
            words_done_next = words_inc;
          end
        end
      end
      OP_HOST_WORD: begin
        if (phase == PH_WDATA) begin
          burst.emit = 1'b1;
          burst.kind = BK_TWO;
          burst.r0   = mk_result(ACT_WR_WORD, OFS_DATA, bus_data, 16'h0000,
                                 {sectors_done, words_done}, 1'b0);
          burst.r1   = after_res;
          phase_next = after_phase;
          if (wrap) begin
            words_done_next       = '0;
            sectors_done_next     = sectors_inc;
            final_poll_next       = (sectors_inc == sectors_total);
            dummy_reads_left_next = DUMMY_INIT;
          end else begin
            words_done_next = words_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/atapio_out.sv]
// result register: holds one item's burst and hands its results out one word at a time
// depends on atapio_pkg

module atapio_out import atapio_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_fire,
  input  burst_t  burst,
  input  logic    out_stall,
  output logic    out_valid,
  output logic    out_last,
  output logic    load_ok,
  output result_t res
);

  logic        busy;
  burst_kind_t kind;
  logic [2:0]  idx;
  result_t     r0;
  result_t     r1;
  logic [7:0]  head;
  logic [23:0] lba_low;
  logic [7:0]  count;
  logic [7:0]  command;
  logic        out_fire;
  result_t     cmd_res;

  assign out_valid = busy;
  assign out_fire  = busy && !out_stall;

  always_comb begin
    case (kind)
      BK_ONE:  out_last = 1'b1;
      BK_TWO:  out_last = (idx == 3'd1);
      BK_CMD:  out_last = (idx == 3'd6);
      default: out_last = 1'b1;
    endcase
  end

  // input side may load once the last word of the held burst leaves
  assign load_ok = !busy || (out_fire && out_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (in_fire && burst.emit) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (out_fire) begin
      busy <= !out_last;
      idx  <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && burst.emit) begin
      kind    <= burst.kind;
      r0      <= burst.r0;
      r1      <= burst.r1;
      head    <= burst.head;
      lba_low <= burst.lba_low;
      count   <= burst.count;
      command <= burst.command;
    end
  end

  always_comb begin
    unique case (idx)
      3'd0: cmd_res = mk_result(ACT_WR_BYTE, OFS_DRIVE_HEAD, {8'h00, head},
                                16'h0000, 16'h0000, 1'b0);
      3'd1: cmd_res = mk_result(ACT_WR_BYTE, OFS_LBA_HIGH, {8'h00, lba_low[23:16]},
                                16'h0000, 16'h0000, 1'b0);
      3'd2: cmd_res = mk_result(ACT_WR_BYTE, OFS_LBA_MID, {8'h00, lba_low[15:8]},
                                16'h0000, 16'h0000, 1'b0);
      3'd3: cmd_res = mk_result(ACT_WR_BYTE, OFS_LBA_LOW, {8'h00, lba_low[7:0]},
                                16'h0000, 16'h0000, 1'b0);
      3'd4: cmd_res = mk_result(ACT_WR_BYTE, OFS_COUNT, {8'h00, count},
                                16'h0000, 16'h0000, 1'b0);
      3'd5: cmd_res = mk_result(ACT_WR_BYTE, OFS_CMD_STATUS, {8'h00, command},
                                16'h0000, 16'h0000, 1'b0);
      default: cmd_res = status_read();
    endcase
  end

  always_comb begin
    case (kind)
      BK_CMD:  res = cmd_res;
      BK_TWO:  res = (idx == 3'd0) ? r0 : r1;
      default: res = r0;
    endcase
  end

endmodule

[rtl/ata_pio_sector_transfer_host.sv]
// Host-side ATA PIO LBA28 sector transfer sequencer. Each accepted item (start,
// bus read return, host word) is decoded in the cycle it is accepted and its
// results, one to seven, are held in an output register and handed out one per
// cycle while out_stall is low, so items that cause at most one result can be
// accepted every cycle; an item that causes several results holds the input
// side while the output register drains them (seven for the command issue, two
// for each data word). Items that do not fit the current phase are taken and
// dropped. drive_select sits at word address 0 of the register port.
// depends on atapio_pkg, atapio_seq, atapio_out

module ata_pio_sector_transfer_host import atapio_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // item input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [27:0] lba,
  input  logic [7:0]  sector_count,
  input  logic [15:0] bus_data,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [2:0]  port_offset,
  output logic [15:0] write_value,
  output logic [15:0] host_word,
  output logic [15:0] word_position,
  output logic        success,
  output logic        last
);

  logic    drive_select;
  logic    in_fire;
  logic    load_ok;
  burst_t  burst;
  phase_t  phase;
  result_t res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_select <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_DRIVE_SELECT)) begin
      drive_select <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_DRIVE_SELECT) ? {31'd0, drive_select} : 32'd0;

  assign in_stall = !load_ok;
  assign in_fire  = in_valid && load_ok;

  atapio_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_fire      (in_fire),
    .operation    (operation),
    .lba          (lba),
    .sector_count (sector_count),
    .bus_data     (bus_data),
    .drive_select (drive_select),
    .burst        (burst),
    .phase        (phase)
  );

  atapio_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .burst     (burst),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_last  (last),
    .load_ok   (load_ok),
    .res       (res)
  );

  assign action        = res.action;
  assign port_offset   = res.port_offset;
  assign write_value   = res.write_value;
  assign host_word     = res.host_word;
  assign word_position = res.word_position;
  assign success       = res.success;

`ifndef NO_ASSERTIONS
  // a burst never ends early
  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("burst ended before its last word");

  // success only rides on a finished word
  a_success_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && success |-> action == ACT_DONE && last)
    else $error("success outside finished");

  // a finished word always returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && action == ACT_DONE |-> phase == PH_IDLE)
    else $error("finished while transfer still active");

  // buffer positions only on data movement
  a_position_scope: assert property (@(posedge clk) disable iff (rst)
    out_valid && word_position != 16'd0 |->
      action == ACT_WR_WORD || action == ACT_HOST_OUT || action == ACT_HOST_WANT)
    else $error("word position on a non-data word");
`endif

endmodule
